// ===== rtl/clkag_pkg.sv =====
// Shared constants and arithmetic helpers for the color/luma key alpha generator.
// No dependencies; the core imports it.
package clkag_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned IndexW = 8;

  localparam int unsigned InDataW  = 3 * ChanW;
  localparam int unsigned OutDataW = 4 * ChanW;

  // Grey weights, applied as floor(x * weight / 255).
  localparam logic [ProdW-1:0] WeightBlue  = 16'd28;
  localparam logic [ProdW-1:0] WeightGreen = 16'd150;
  localparam logic [ProdW-1:0] WeightRed   = 16'd76;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ChanW-1:0] AlphaClear  = 8'h00;

  // Alpha mode codes.
  localparam logic [ModeW-1:0] ModeGrey   = 3'd0;
  localparam logic [ModeW-1:0] ModeEqual  = 3'd1;
  localparam logic [ModeW-1:0] ModeGe     = 3'd2;
  localparam logic [ModeW-1:0] ModeLe     = 3'd3;
  localparam logic [ModeW-1:0] ModeGt     = 3'd4;
  localparam logic [ModeW-1:0] ModeLt     = 3'd5;
  localparam logic [ModeW-1:0] ModeOpaque = 3'd6;
  localparam logic [ModeW-1:0] ModeReset  = ModeOpaque;

  // Register indexes on the configuration port.
  localparam logic [IndexW-1:0] RegKeyRed   = 8'd0;
  localparam logic [IndexW-1:0] RegKeyGreen = 8'd1;
  localparam logic [IndexW-1:0] RegKeyBlue  = 8'd2;
  localparam logic [IndexW-1:0] RegMode     = 8'd3;

  // Per-channel weighted product.
  function automatic logic [ProdW-1:0] weigh(input logic [ChanW-1:0] x,
                                             input logic [ProdW-1:0] w);
    logic [2*ProdW-1:0] p;
    begin
      p = {{ProdW{1'b0}}, {(ProdW-ChanW){1'b0}}, x} * {{ProdW{1'b0}}, w};
      return p[ProdW-1:0];
    end
  endfunction

  // Exact floor(x / 255) for any x below 65535: (x + 1 + (x >> 8)) >> 8.
  // The products stay below 38251, so the quotient fits in 8 bits.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] s;
    begin
      s = {1'b0, x} + {{(ProdW-ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + 17'd1;
      return s[ChanW+ChanW-1:ChanW];
    end
  endfunction

endpackage

// ===== rtl/color_or_luma_key_alpha_generator_core.sv =====
// Color or luma key alpha generator: pixel stream in, pixel plus alpha out.
// Depends on clkag_pkg for weights, mode codes and the divide-by-255 helper.
//
// Usage. Pixels enter on the s_axis channel, one beat per pixel, blue in the
// low byte, then green, then red. Each leaves on the m_axis channel with the
// same three bytes and an alpha byte on top. Alpha is chosen by the mode
// register: pixel grey, exact key-color match, one of four comparisons of the
// key grey against the pixel grey, or always opaque (codes 6 and 7).
// Grey is floor(b*28/255) + floor(g*150/255) + floor(r*76/255).
//
// The pipeline has four register stages: weighted products, divide by 255,
// grey sum, alpha select. A new beat is accepted every cycle while the
// receiver keeps up and no configuration write is under way, so throughput
// is one pixel per clock. The per-stage arithmetic (one constant multiply,
// one add and shift, one three-input add, one compare) sets the clock.
//
// When the receiver holds m_axis_tready low while a beat waits, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Configuration is written on the cfg channel, which is always ready; during
// a cycle with cfg_valid high no pixel is taken. The key grey follows the key
// registers through its own three-stage pipeline, which settles before any
// pixel taken after the write reaches the select stage. Reset (rst, sync,
// active high) empties the pipeline, clears the key to black and sets the
// mode to opaque.
module color_or_luma_key_alpha_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  // Input pixels. tdata: [7:0] in_blue, [15:8] in_green, [23:16] in_red.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [clkag_pkg::InDataW-1:0]  s_axis_tdata,
  // Output pixels. tdata: [7:0] out_blue, [15:8] out_green, [23:16] out_red,
  // [31:24] alpha.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [clkag_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clkag_pkg::IndexW-1:0]   cfg_index,
  input  logic [clkag_pkg::ChanW-1:0]    cfg_data
);
  import clkag_pkg::*;

  // Configuration registers.
  logic [ChanW-1:0] key_red;
  logic [ChanW-1:0] key_green;
  logic [ChanW-1:0] key_blue;
  logic [ModeW-1:0] alpha_mode;

  // Key grey pipeline, free running.
  logic [ProdW-1:0] kprod_b, kprod_g, kprod_r;
  logic [ChanW-1:0] kterm_b, kterm_g, kterm_r;
  logic [ChanW-1:0] key_grey;

  // Pixel pipeline.
  logic             v1, v2, v3, v4;
  logic [ChanW-1:0] p1_b, p1_g, p1_r;
  logic [ProdW-1:0] prod_b, prod_g, prod_r;
  logic [ChanW-1:0] p2_b, p2_g, p2_r;
  logic [ChanW-1:0] term_b, term_g, term_r;
  logic [ChanW-1:0] p3_b, p3_g, p3_r;
  logic [ChanW-1:0] grey3;
  logic [ChanW-1:0] p4_b, p4_g, p4_r;
  logic [ChanW-1:0] alpha4;
  logic [ChanW-1:0] alpha_next;
  logic [ChanW+1:0] grey_sum;

  logic advance;
  logic take;

  assign advance       = !v4 || m_axis_tready;
  assign s_axis_tready = advance && !cfg_valid;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_red    <= '0;
      key_green  <= '0;
      key_blue   <= '0;
      alpha_mode <= ModeReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKeyRed:   key_red    <= cfg_data;
        RegKeyGreen: key_green  <= cfg_data;
        RegKeyBlue:  key_blue   <= cfg_data;
        RegMode:     alpha_mode <= cfg_data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kprod_b  <= weigh(key_blue, WeightBlue);
    kprod_g  <= weigh(key_green, WeightGreen);
    kprod_r  <= weigh(key_red, WeightRed);
    kterm_b  <= div255(kprod_b);
    kterm_g  <= div255(kprod_g);
    kterm_r  <= div255(kprod_r);
    key_grey <= kterm_b + kterm_g + kterm_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign grey_sum = {2'b00, term_b} + {2'b00, term_g} + {2'b00, term_r};

  always_comb begin
    case (alpha_mode)
      ModeGrey:  alpha_next = grey3;
      ModeEqual: alpha_next = (p3_b == key_blue && p3_g == key_green && p3_r == key_red)
                              ? AlphaClear : AlphaOpaque;
      ModeGe:    alpha_next = (key_grey >= grey3) ? AlphaClear : AlphaOpaque;
      ModeLe:    alpha_next = (key_grey <= grey3) ? AlphaClear : AlphaOpaque;
      ModeGt:    alpha_next = (key_grey >  grey3) ? AlphaClear : AlphaOpaque;
      ModeLt:    alpha_next = (key_grey <  grey3) ? AlphaClear : AlphaOpaque;
      default:   alpha_next = AlphaOpaque;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // Stage 1: weighted products.
      p1_b   <= s_axis_tdata[ChanW-1:0];
      p1_g   <= s_axis_tdata[2*ChanW-1:ChanW];
      p1_r   <= s_axis_tdata[3*ChanW-1:2*ChanW];
      prod_b <= weigh(s_axis_tdata[ChanW-1:0], WeightBlue);
      prod_g <= weigh(s_axis_tdata[2*ChanW-1:ChanW], WeightGreen);
      prod_r <= weigh(s_axis_tdata[3*ChanW-1:2*ChanW], WeightRed);
      // Stage 2: exact floor division by 255.
      p2_b   <= p1_b;
      p2_g   <= p1_g;
      p2_r   <= p1_r;
      term_b <= div255(prod_b);
      term_g <= div255(prod_g);
      term_r <= div255(prod_r);
      // Stage 3: grey sum, at most 254.
      p3_b   <= p2_b;
      p3_g   <= p2_g;
      p3_r   <= p2_r;
      grey3  <= grey_sum[ChanW-1:0];
      // Stage 4: alpha select.
      p4_b   <= p3_b;
      p4_g   <= p3_g;
      p4_r   <= p3_r;
      alpha4 <= alpha_next;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {alpha4, p4_r, p4_g, p4_b};

`ifndef SYNTHESIS
  // A configuration write cycle never takes a pixel.
  a_no_take_on_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> !s_axis_tready)
    else $error("pixel accepted during a configuration write");

  // In opaque mode every delivered beat carries full alpha.
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && alpha_mode == ModeOpaque) |-> m_axis_tdata[31:24] == AlphaOpaque)
    else $error("opaque mode produced a non-opaque alpha");

  // Grey never reaches 255.
  a_grey_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && alpha_mode == ModeGrey) |-> m_axis_tdata[31:24] != AlphaOpaque)
    else $error("grey alpha out of range");

  // An accepted pixel reaches stage one on the next edge.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted pixel lost at pipeline entry");
`endif

endmodule

// ===== sim/tb_color_or_luma_key_alpha_generator_core.sv =====
// Self-checking testbench for color_or_luma_key_alpha_generator_core.
// Needs only clkag_pkg and the core. A queue-fed driver, a random-stall receiver
// and a clocked monitor check every output pixel against a local alpha predictor.
module tb_color_or_luma_key_alpha_generator_core;
  import clkag_pkg::*;

  // Pixel layouts as they sit on the stream buses, lowest byte last.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } keyed_pixel_t;

  // The spare mode code has no package name; it behaves like opaque.
  localparam logic [ModeW-1:0]  ModeSpare      = 3'd7;
  // Indexes from here up address no register and must be ignored.
  localparam logic [IndexW-1:0] RegFirstUnused = 8'd4;
  // Pipeline depth is four; SettleCycles is the wait that lets it drain completely.
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 200000;
  localparam int LongHoldOff  = 400;
  localparam int Segments     = 16;
  localparam int SegmentBeats = 108;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // All block inputs start at known values.
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [IndexW-1:0]   cfg_index     = '0;
  logic [ChanW-1:0]    cfg_data      = '0;

  color_or_luma_key_alpha_generator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixels waiting to be offered, and keyed pixels the block still owes us.
  pixel_t       pixel_queue[$];
  keyed_pixel_t expected_pixels[$];

  // Local copy of the key and mode registers, tracked from accepted writes.
  pixel_t           key_color;
  logic [ModeW-1:0] key_mode;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_request   = 0;
  int  hold_left      = 0;
  int  mismatches     = 0;
  int  beats_checked  = 0;
  int  cycle_count    = 0;
  bit  pixel_taken    = 1'b0;

  // Weighted grey level, each term an exact floor division by 255.
  function automatic logic [ChanW-1:0] grey_level(input pixel_t p);
    int unsigned sum;
    sum = (int'(p.blue)  * int'(WeightBlue))  / 255
        + (int'(p.green) * int'(WeightGreen)) / 255
        + (int'(p.red)   * int'(WeightRed))   / 255;
    return sum[ChanW-1:0];
  endfunction

  // Predicts the output beat for one input pixel under the current registers.
  function automatic keyed_pixel_t keyed_pixel(input pixel_t p);
    keyed_pixel_t     k;
    logic [ChanW-1:0] pix_grey;
    logic [ChanW-1:0] key_grey;
    pix_grey = grey_level(p);
    key_grey = grey_level(key_color);
    k.blue   = p.blue;
    k.green  = p.green;
    k.red    = p.red;
    case (key_mode)
      ModeGrey:  k.alpha = pix_grey;
      ModeEqual: k.alpha = (p == key_color)        ? AlphaClear : AlphaOpaque;
      ModeGe:    k.alpha = (key_grey >= pix_grey)  ? AlphaClear : AlphaOpaque;
      ModeLe:    k.alpha = (key_grey <= pix_grey)  ? AlphaClear : AlphaOpaque;
      ModeGt:    k.alpha = (key_grey >  pix_grey)  ? AlphaClear : AlphaOpaque;
      ModeLt:    k.alpha = (key_grey <  pix_grey)  ? AlphaClear : AlphaOpaque;
      default:   k.alpha = AlphaOpaque;
    endcase
    return k;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at output beat %0d: %s got 0x%0h want 0x%0h",
             beats_checked, what, got, want);
    mismatches++;
  endtask

  // Monitor: register writes, input acceptance and output checks all happen
  // on the rising edge, reading values from before the edge's updates.
  always @(posedge clk) begin
    keyed_pixel_t got;
    keyed_pixel_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_color_or_luma_key_alpha_generator_core NOT OK");
      $finish;
    end else if (rst) begin
      key_color = '0;
      key_mode  = ModeReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegKeyRed:   key_color.red   = cfg_data;
          RegKeyGreen: key_color.green = cfg_data;
          RegKeyBlue:  key_color.blue  = cfg_data;
          RegMode:     key_mode        = cfg_data[ModeW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(keyed_pixel(pixel_t'(s_axis_tdata)));
        pixel_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected beat", int'(got), 0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.blue != want.blue)
            report_mismatch("out_blue", int'(got.blue), int'(want.blue));
          if (got.green != want.green)
            report_mismatch("out_green", int'(got.green), int'(want.green));
          if (got.red != want.red)
            report_mismatch("out_red", int'(got.red), int'(want.red));
          if (got.alpha != want.alpha)
            report_mismatch("alpha", int'(got.alpha), int'(want.alpha));
        end
        beats_checked++;
      end
    end
  end

  // Driver: on the falling edge, retire a beat taken at the last rising edge
  // and either offer the next pending pixel or idle.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    pixel_taken = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request that it counts
  // down itself so that the pipeline backs up into the input.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Waits until every pixel has gone in and come out, then lets the
  // pipeline settle before anything touches the registers.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Raises or keeps the write channel up and waits for its handshake.
  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [ChanW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads a whole key setting once the block is idle. Writes to unused
  // indexes follow so that any of them clobbering a register shows up.
  task automatic apply_setting(input pixel_t key, input logic [ChanW-1:0] mode_data,
                               input int junk_writes);
    wait_idle();
    write_reg(RegKeyRed, key.red);
    write_reg(RegKeyGreen, key.green);
    write_reg(RegKeyBlue, key.blue);
    write_reg(RegMode, mode_data);
    repeat (junk_writes)
      write_reg(IndexW'($urandom_range(255, RegFirstUnused)), ChanW'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A channel value biased toward the extremes.
  function automatic logic [ChanW-1:0] draw_channel();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  // Random pixel: often the key itself or a one-bit neighbor of it, so that
  // exact matches and equal or adjacent grey levels come up regularly.
  function automatic pixel_t draw_pixel(input pixel_t key);
    pixel_t p;
    case ($urandom_range(3))
      0: p = key;
      1: begin
        p = key;
        p[$urandom_range(InDataW-1)] ^= 1'b1;
      end
      default: p = pixel_t'(InDataW'($urandom));
    endcase
    return p;
  endfunction

  initial begin
    pixel_t           dir_key;
    pixel_t           seg_key;
    logic [ChanW-1:0] seg_mode;
    int               phase;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: black key, opaque mode.
    pixel_queue.push_back('{red: 8'h00, green: 8'h00, blue: 8'h00});
    pixel_queue.push_back('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});

    // Grey passthrough, one full channel at a time.
    dir_key = '{red: 8'h40, green: 8'h80, blue: 8'h20};
    apply_setting(dir_key, {5'd0, ModeGrey}, 0);
    pixel_queue.push_back('{red: 8'hFF, green: 8'h00, blue: 8'h00});
    pixel_queue.push_back('{red: 8'h00, green: 8'hFF, blue: 8'h00});
    pixel_queue.push_back('{red: 8'h00, green: 8'h00, blue: 8'hFF});

    // Exact key match against near misses in one channel.
    apply_setting(dir_key, {5'd0, ModeEqual}, 0);
    pixel_queue.push_back(dir_key);
    pixel_queue.push_back('{red: 8'h40, green: 8'h80, blue: 8'h21});
    pixel_queue.push_back('{red: 8'h41, green: 8'h80, blue: 8'h20});

    // Each comparison with equal, lower and higher pixel grey.
    for (int m = ModeGe; m <= ModeLt; m++) begin
      apply_setting(dir_key, ChanW'(m), 0);
      pixel_queue.push_back(dir_key);
      pixel_queue.push_back('{red: 8'h00, green: 8'h00, blue: 8'h00});
      pixel_queue.push_back('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    end

    // White key; the mode data carries set bits above the mode width.
    apply_setting('{red: 8'hFF, green: 8'hFF, blue: 8'hFF}, {5'b11111, ModeGe}, 0);
    pixel_queue.push_back('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    pixel_queue.push_back('{red: 8'h00, green: 8'h00, blue: 8'h00});

    // Black key, equal grey at zero.
    apply_setting('{red: 8'h00, green: 8'h00, blue: 8'h00}, {5'd0, ModeLe}, 0);
    pixel_queue.push_back('{red: 8'h00, green: 8'h00, blue: 8'h00});

    // Spare mode code, followed by writes to unused indexes.
    apply_setting(dir_key, {5'b11111, ModeSpare}, 3);
    pixel_queue.push_back('{red: 8'h12, green: 8'h34, blue: 8'h56});

    // Random segments: each mode twice, all four idling patterns, a fresh
    // key every time, and a long receiver hold-off in two of them.
    for (int seg = 0; seg < Segments; seg++) begin
      phase    = seg % 4;
      seg_key  = '{red: draw_channel(), green: draw_channel(), blue: draw_channel()};
      seg_mode = {($urandom_range(1) != 0) ? 5'($urandom) : 5'd0, ModeW'(seg % 8)};
      apply_setting(seg_key, seg_mode, $urandom_range(2));
      @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (seg == 0 || seg == Segments / 2) hold_request = LongHoldOff;
      repeat (SegmentBeats) pixel_queue.push_back(draw_pixel(seg_key));
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_color_or_luma_key_alpha_generator_core OK");
    end else begin
      $display("tb_color_or_luma_key_alpha_generator_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== color_or_luma_key_alpha_generator_core.f =====
rtl/clkag_pkg.sv
rtl/color_or_luma_key_alpha_generator_core.sv
sim/tb_color_or_luma_key_alpha_generator_core.sv
